FILE: hw/rtl/ssdw_pkg.sv
package ssdw_pkg;

    // field widths
    localparam int VAL_W   = 27;
    localparam int POS_W   = 3;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 4;

    // display geometry
    localparam int NUM_POS_MAX = 8;

    // divide by ten through reciprocal multiply: q = (v * RECIP) >> RECIP_SHIFT
    localparam int             RECIP_W     = 32;
    localparam logic [31:0]    RECIP       = 32'hCCCC_CCCD;
    localparam int             RECIP_SHIFT = 35;
    localparam int             QUOT_W      = VAL_W - 3;

    // digit codes
    localparam logic [DATA_W-1:0] POINT_BIT  = 8'h80;
    localparam logic [DATA_W-1:0] BLANK_CODE = 8'h0F;

    // reset value of the position count register
    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

    typedef enum logic [1:0] {
        OP_NUMBER = 2'd0,
        OP_DIGIT  = 2'd1,
        OP_POINT  = 2'd2,
        OP_BLANK  = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] reg_addr;
        logic [DATA_W-1:0] reg_data;
        logic              overflow;
        logic              last;
    } t_result;

    // smallest number with k+1 decimal digits
    function automatic logic [VAL_W-1:0] pow10(input logic [COUNT_W-1:0] k);
        logic [VAL_W-1:0] p;
        case (k)
            4'd1:    p = 27'd10;
            4'd2:    p = 27'd100;
            4'd3:    p = 27'd1000;
            4'd4:    p = 27'd10000;
            4'd5:    p = 27'd100000;
            4'd6:    p = 27'd1000000;
            4'd7:    p = 27'd10000000;
            4'd8:    p = 27'd100000000;
            default: p = 27'd1;
        endcase
        return p;
    endfunction

endpackage

FILE: hw/rtl/seven_segment_digit_writer.sv
// Turns display commands into digit-register writes (address 1..8, data byte with the
// decimal point in bit 7) for a code-B seven-segment driver. A command is taken when start
// is high and busy is low. Write digit, set decimal point and blank digit give one write on
// the cycle after acceptance and never raise busy; a position at or above MAX_DIGITS gives
// none. Write number splits the value into decimal digits, most significant position written
// last, through one shared divide-by-ten unit: each of the positions in use (1..MAX_DIGITS)
// takes a multiply step, then a remainder-and-write step, and busy stays high until the
// last write is issued. Each write shows on o_result with o_strobe high for exactly one cycle;
// the receiver cannot hold it off and must take it then. The user must write the position count
// through i_cfg_we/i_cfg_data only while no command is at work; the block does not enforce it.
module seven_segment_digit_writer import ssdw_pkg::*; #(
    parameter int MAX_DIGITS = NUM_POS_MAX
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data,
    output logic               o_strobe,
    output t_result            o_result
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DIGITS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_count;
    logic [DATA_W-1:0]    r_store [MAX_DIGITS];
    logic [MAX_DIGITS-1:0] r_mask, n_mask;
    logic [VAL_W-1:0]     r_val, n_val;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_ovf, n_ovf;
    logic                 r_strobe, n_strobe;
    t_result              r_result, n_result;

    logic                 w_accept;
    logic [COUNT_W-1:0]   w_used;
    logic                 w_pos_ok;
    logic [IDX_W-1:0]     w_cmd_idx;
    logic [IDX_W-1:0]     w_seq_idx;
    logic                 w_wr;
    logic [IDX_W-1:0]     w_wr_idx;
    logic [DATA_W-1:0]    w_wr_data;
    logic                 w_step;
    logic [VAL_W-1:0]     w_quot;
    logic [3:0]           w_rem;
    logic [DATA_W-1:0]    w_digit;

    // shared divide-by-ten unit
    ssdw_div10 u_div10 (
        .i_clk      (i_clk),
        .i_step     (w_step),
        .i_dividend (r_val),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_step   = (r_state == S_MUL);

    // positions in use, clamped to 1..MAX_DIGITS
    always_comb begin
        w_used = r_count;
        if (w_used == '0) begin
            w_used = COUNT_W'(1);
        end
        if (w_used > MAX_CNT) begin
            w_used = MAX_CNT;
        end
    end

    assign w_pos_ok  = ({1'b0, i_cmd.position} < MAX_CNT);
    assign w_cmd_idx = IDX_W'(i_cmd.position);
    assign w_seq_idx = IDX_W'(r_pos);

    // digit of a number, point added where the mask has one; blank once the value left is zero
    always_comb begin
        if (r_val != '0) begin
            w_digit = {4'h0, w_rem} | (r_mask[w_seq_idx] ? POINT_BIT : '0);
        end else begin
            w_digit = BLANK_CODE;
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_mask    = r_mask;
        n_val     = r_val;
        n_pos     = r_pos;
        n_ovf     = r_ovf;
        n_strobe  = 1'b0;
        n_result  = r_result;
        w_wr      = 1'b0;
        w_wr_idx  = w_cmd_idx;
        w_wr_data = BLANK_CODE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.op)
                        OP_NUMBER: begin
                            n_val   = i_cmd.value;
                            n_pos   = POS_W'(w_used - COUNT_W'(1));
                            n_ovf   = (i_cmd.value >= pow10(w_used));
                            n_state = S_MUL;
                        end
                        OP_DIGIT: begin
                            w_wr      = w_pos_ok;
                            w_wr_data = i_cmd.value[DATA_W-1:0]
                                      | (r_mask[w_cmd_idx] ? POINT_BIT : '0);
                        end
                        OP_POINT: begin
                            w_wr      = w_pos_ok;
                            w_wr_data = r_store[w_cmd_idx] | POINT_BIT;
                            if (w_pos_ok) begin
                                n_mask[w_cmd_idx] = 1'b1;
                            end
                        end
                        OP_BLANK: begin
                            w_wr      = w_pos_ok;
                            w_wr_data = BLANK_CODE;
                        end
                        default: begin
                            w_wr = 1'b0;
                        end
                    endcase
                    if (w_wr) begin
                        n_strobe          = 1'b1;
                        n_result.reg_addr = ADDR_W'(i_cmd.position) + ADDR_W'(1);
                        n_result.reg_data = w_wr_data;
                        n_result.overflow = 1'b0;
                        n_result.last     = 1'b1;
                    end
                end
            end
            S_MUL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                w_wr              = 1'b1;
                w_wr_idx          = w_seq_idx;
                w_wr_data         = w_digit;
                n_strobe          = 1'b1;
                n_result.reg_addr = ADDR_W'(r_pos) + ADDR_W'(1);
                n_result.reg_data = w_digit;
                n_result.overflow = r_ovf;
                n_result.last     = (r_pos == '0);
                n_val             = w_quot;
                n_pos             = r_pos - POS_W'(1);
                n_state           = (r_pos == '0) ? S_IDLE : S_MUL;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= COUNT_RESET;
            r_mask   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mask   <= n_mask;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
        end
    end

    // digit store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_store[i] <= '0;
            end
        end else if (w_wr) begin
            r_store[w_wr_idx] <= w_wr_data;
        end
    end

    // working value and output beat
    always_ff @(posedge i_clk) begin
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_ovf    <= n_ovf;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

FILE: hw/rtl/ssdw_div10.sv
module ssdw_div10 import ssdw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_step,
    input  logic [VAL_W-1:0] i_dividend,
    output logic [VAL_W-1:0] o_quot,
    output logic [3:0]       o_rem
);

    logic [QUOT_W-1:0]          r_quot;
    logic [VAL_W+RECIP_W-1:0]   w_prod;
    logic [VAL_W-1:0]           w_ten;
    logic [VAL_W-1:0]           w_diff;

    // reciprocal multiply, quotient registered
    assign w_prod = {{RECIP_W{1'b0}}, i_dividend} * {{VAL_W{1'b0}}, RECIP};

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_quot <= w_prod[RECIP_SHIFT +: QUOT_W];
        end
    end

    // remainder from the held dividend: v - 10*q
    assign w_ten  = {r_quot, 3'b000} + {2'b00, r_quot, 1'b0};
    assign w_diff = i_dividend - w_ten;
    assign o_rem  = w_diff[3:0];
    assign o_quot = {3'b000, r_quot};

endmodule
